@@ rtl/cfcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_pkg
// Shared constants and control/status types for the checksum frame receiver.
// ----------------------------------------------------------------------------
package cfcr_pkg;

    localparam logic [7:0] HDR_SYNC     = 8'hAA;
    localparam logic [7:0] HDR_RX_ID    = 8'hAF;
    localparam logic [7:0] ACK_CODE     = 8'hF0;
    localparam logic [7:0] ACK_LEN_BYTE = 8'h03;
    localparam logic [7:0] ACK_TAG      = 8'hBA;
    localparam logic [7:0] GAIN_LEN_BYTE = 8'h12;
    localparam logic [7:0] GAIN_CODE_LO = 8'h10;
    localparam logic [7:0] GAIN_CODE_HI = 8'h11;

    localparam logic [7:0] FN_CAL     = 8'h01;
    localparam logic [7:0] FN_READ    = 8'h02;
    localparam logic [7:0] FN_SET_LO  = 8'h10;
    localparam logic [7:0] FN_SET_HI  = 8'h11;
    localparam logic [7:0] FN_SAVE    = 8'h12;
    localparam logic [7:0] SUB_READ   = 8'h01;
    localparam logic [7:0] SUB_ACC    = 8'h01;
    localparam logic [7:0] SUB_GYRO   = 8'h02;
    localparam logic [7:0] SUB_BOTH   = 8'h03;

    localparam logic [7:0] NEED_ANY   = 8'd3;
    localparam logic [7:0] NEED_SHORT = 8'd5;
    localparam logic [7:0] NEED_GAINS = 8'd22;

    localparam int PAYLOAD_LEN = 18;
    localparam int GAIN_COUNT  = 18;
    localparam int GAIN_HALF   = 9;
    localparam int GAIN_IDX_W  = $clog2(GAIN_COUNT);
    localparam int STG_IDX_W   = $clog2(PAYLOAD_LEN);

    localparam logic [7:0] PAYLOAD_FIRST = 8'd4;
    localparam logic [7:0] PAYLOAD_END   = 8'd22;

    localparam logic [4:0] GAIN_FRAME_LAST = 5'd22;
    localparam logic [4:0] ACK_FRAME_LAST  = 5'd7;

    localparam logic [1:0] FS_OK       = 2'd0;
    localparam logic [1:0] FS_BAD_SUM  = 2'd1;
    localparam logic [1:0] FS_BAD_HDR  = 2'd2;
    localparam logic [1:0] FS_SHORT    = 2'd3;

    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_CAL  = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_ACK  = 2'd3;

    typedef struct packed {
        logic       rx_take;
        logic       out_load;
        logic       out_single;
        logic       out_last;
        logic       kind_ack;
        logic       frame_hi;
        logic [4:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] act;
    } t_dp_stat;

endpackage

@@ rtl/cfcr_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_datapath
// Frame parsing registers, gain store, reply byte generator, output register.
// ----------------------------------------------------------------------------
module cfcr_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_rx_last,
    input  cfcr_pkg::t_dp_cmd i_cmd,
    output cfcr_pkg::t_dp_stat o_stat,
    output logic [7:0]        o_tx_byte,
    output logic              o_byte_valid,
    output logic              o_last_of_run,
    output logic [1:0]        o_frame_status,
    output logic              o_acc_cal,
    output logic              o_gyro_cal,
    output logic              o_save
);

    localparam int STG_W = cfcr_pkg::STG_IDX_W;
    localparam logic [4:0] GAIN_SUM_POS = cfcr_pkg::GAIN_FRAME_LAST;

    logic [7:0]  r_sum, n_sum;
    logic [7:0]  r_pos, n_pos;
    logic        r_hdr, n_hdr;
    logic [7:0]  r_func, n_func;
    logic [7:0]  r_sub, n_sub;
    logic [7:0]  r_stage [cfcr_pkg::PAYLOAD_LEN];
    logic [15:0] r_gain  [cfcr_pkg::GAIN_COUNT];
    logic [7:0]  r_ack_check;
    logic        r_save_pend;
    logic [7:0]  r_tx_sum;

    logic [7:0]  r_tx;
    logic        r_bv;
    logic        r_last;
    logic [1:0]  r_status;
    logic        r_acc;
    logic        r_gyro;
    logic        r_save;

    logic [1:0]  status;
    logic [1:0]  act;
    logic [7:0]  need;
    logic        eof_take;
    logic        byte_take;
    logic        commit_lo;
    logic        commit_hi;
    logic [STG_W-1:0] stg_idx;
    logic [3:0]  half;
    logic [cfcr_pkg::GAIN_IDX_W-1:0] gidx;
    logic [15:0] gval;
    logic [7:0]  rep_byte;

    assign eof_take  = i_cmd.rx_take & i_rx_last;
    assign byte_take = i_cmd.rx_take & ~i_rx_last;
    assign stg_idx   = STG_W'(r_pos - cfcr_pkg::PAYLOAD_FIRST);

    // frame checks, in order: checksum, header, length
    always_comb begin
        need = cfcr_pkg::NEED_ANY;
        if (r_func == cfcr_pkg::FN_CAL || r_func == cfcr_pkg::FN_READ) begin
            need = cfcr_pkg::NEED_SHORT;
        end else if (r_func == cfcr_pkg::FN_SET_LO || r_func == cfcr_pkg::FN_SET_HI) begin
            need = cfcr_pkg::NEED_GAINS;
        end
        if (r_sum != i_rx_byte) begin
            status = cfcr_pkg::FS_BAD_SUM;
        end else if (!(r_hdr && r_pos >= 8'd2)) begin
            status = cfcr_pkg::FS_BAD_HDR;
        end else if (r_pos < need) begin
            status = cfcr_pkg::FS_SHORT;
        end else begin
            status = cfcr_pkg::FS_OK;
        end
        act = cfcr_pkg::ACT_NONE;
        if (status == cfcr_pkg::FS_OK) begin
            case (r_func)
                cfcr_pkg::FN_CAL:    act = cfcr_pkg::ACT_CAL;
                cfcr_pkg::FN_READ:   act = (r_sub == cfcr_pkg::SUB_READ) ?
                                           cfcr_pkg::ACT_READ : cfcr_pkg::ACT_NONE;
                cfcr_pkg::FN_SET_LO,
                cfcr_pkg::FN_SET_HI,
                cfcr_pkg::FN_SAVE:   act = cfcr_pkg::ACT_ACK;
                default:             act = cfcr_pkg::ACT_NONE;
            endcase
        end
    end

    assign o_stat.act = act;
    assign commit_lo  = eof_take && status == cfcr_pkg::FS_OK && r_func == cfcr_pkg::FN_SET_LO;
    assign commit_hi  = eof_take && status == cfcr_pkg::FS_OK && r_func == cfcr_pkg::FN_SET_HI;

    always_comb begin
        n_sum  = r_sum;
        n_pos  = r_pos;
        n_hdr  = r_hdr;
        n_func = r_func;
        n_sub  = r_sub;
        if (eof_take) begin
            n_sum  = '0;
            n_pos  = '0;
            n_hdr  = 1'b0;
            n_func = '0;
            n_sub  = '0;
        end else if (byte_take) begin
            if (r_pos == 8'd0) begin
                n_hdr = (i_rx_byte == cfcr_pkg::HDR_SYNC);
            end else if (r_pos == 8'd1) begin
                n_hdr = r_hdr && (i_rx_byte == cfcr_pkg::HDR_RX_ID);
            end
            if (r_pos == 8'd2) begin
                n_func = i_rx_byte;
            end
            if (r_pos == cfcr_pkg::PAYLOAD_FIRST) begin
                n_sub = i_rx_byte;
            end
            n_sum = r_sum + i_rx_byte;
            if (r_pos != 8'hFF) begin
                n_pos = r_pos + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_hdr  <= 1'b0;
            r_func <= '0;
            r_sub  <= '0;
        end else begin
            r_sum  <= n_sum;
            r_pos  <= n_pos;
            r_hdr  <= n_hdr;
            r_func <= n_func;
            r_sub  <= n_sub;
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_take && r_pos >= cfcr_pkg::PAYLOAD_FIRST && r_pos < cfcr_pkg::PAYLOAD_END) begin
            r_stage[stg_idx] <= i_rx_byte;
        end
        if (eof_take) begin
            r_ack_check <= i_rx_byte;
            r_save_pend <= (act == cfcr_pkg::ACT_ACK) && (r_func == cfcr_pkg::FN_SAVE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < cfcr_pkg::GAIN_COUNT; i++) begin
                r_gain[i] <= '0;
            end
        end else begin
            for (int i = 0; i < cfcr_pkg::GAIN_HALF; i++) begin
                if (commit_lo) begin
                    r_gain[i] <= {r_stage[2*i], r_stage[2*i+1]};
                end
                if (commit_hi) begin
                    r_gain[cfcr_pkg::GAIN_HALF + i] <= {r_stage[2*i], r_stage[2*i+1]};
                end
            end
        end
    end

    // reply byte at position idx of the current reply frame
    always_comb begin
        half = 4'((i_cmd.idx - 5'd4) >> 1);
        gidx = i_cmd.frame_hi ? (cfcr_pkg::GAIN_IDX_W'(half) +
                                 cfcr_pkg::GAIN_IDX_W'(cfcr_pkg::GAIN_HALF))
                              : cfcr_pkg::GAIN_IDX_W'(half);
        gval = 16'h0000;
        if (i_cmd.idx >= 5'd4 && i_cmd.idx < GAIN_SUM_POS) begin
            gval = r_gain[gidx];
        end
        rep_byte = 8'h00;
        if (i_cmd.kind_ack) begin
            case (i_cmd.idx)
                5'd0, 5'd1: rep_byte = cfcr_pkg::HDR_SYNC;
                5'd2:       rep_byte = cfcr_pkg::ACK_CODE;
                5'd3:       rep_byte = cfcr_pkg::ACK_LEN_BYTE;
                5'd4:       rep_byte = cfcr_pkg::ACK_TAG;
                5'd5:       rep_byte = 8'h00;
                5'd6:       rep_byte = r_ack_check;
                default:    rep_byte = r_tx_sum;
            endcase
        end else begin
            case (i_cmd.idx)
                5'd0, 5'd1: rep_byte = cfcr_pkg::HDR_SYNC;
                5'd2:       rep_byte = i_cmd.frame_hi ? cfcr_pkg::GAIN_CODE_HI
                                                      : cfcr_pkg::GAIN_CODE_LO;
                5'd3:       rep_byte = cfcr_pkg::GAIN_LEN_BYTE;
                cfcr_pkg::GAIN_FRAME_LAST: rep_byte = r_tx_sum;
                default:    rep_byte = i_cmd.idx[0] ? gval[7:0] : gval[15:8];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_single) begin
                r_tx     <= 8'h00;
                r_bv     <= 1'b0;
                r_last   <= 1'b1;
                r_status <= status;
                r_acc    <= (act == cfcr_pkg::ACT_CAL) &&
                            (r_sub == cfcr_pkg::SUB_ACC || r_sub == cfcr_pkg::SUB_BOTH);
                r_gyro   <= (act == cfcr_pkg::ACT_CAL) &&
                            (r_sub == cfcr_pkg::SUB_GYRO || r_sub == cfcr_pkg::SUB_BOTH);
                r_save   <= 1'b0;
            end else begin
                r_tx     <= rep_byte;
                r_bv     <= 1'b1;
                r_last   <= i_cmd.out_last;
                r_status <= cfcr_pkg::FS_OK;
                r_acc    <= 1'b0;
                r_gyro   <= 1'b0;
                r_save   <= i_cmd.out_last & r_save_pend;
                r_tx_sum <= (i_cmd.idx == 5'd0) ? rep_byte : r_tx_sum + rep_byte;
            end
        end
    end

    assign o_tx_byte      = r_tx;
    assign o_byte_valid   = r_bv;
    assign o_last_of_run  = r_last;
    assign o_frame_status = r_status;
    assign o_acc_cal      = r_acc;
    assign o_gyro_cal     = r_gyro;
    assign o_save         = r_save;

endmodule

@@ rtl/cfcr_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfcr_controller
// Receive/reply sequencer and output register valid flag.
// ----------------------------------------------------------------------------
module cfcr_controller (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    input  logic               i_s_last,
    output logic               o_s_ready,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    input  cfcr_pkg::t_dp_stat i_stat,
    output cfcr_pkg::t_dp_cmd  o_cmd
);

    localparam logic S_RX    = 1'b0;
    localparam logic S_REPLY = 1'b1;

    logic       r_state, n_state;
    logic       r_kind_ack, n_kind_ack;
    logic       r_frame_hi, n_frame_hi;
    logic [4:0] r_idx, n_idx;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       rx_take;
    logic       frame_end;
    logic       run_end;

    assign out_free  = ~r_out_valid | i_m_ready;
    assign o_s_ready = (r_state == S_RX) & out_free;
    assign rx_take   = i_s_valid & o_s_ready;
    assign frame_end = r_kind_ack ? (r_idx == cfcr_pkg::ACK_FRAME_LAST)
                                  : (r_idx == cfcr_pkg::GAIN_FRAME_LAST);
    assign run_end   = frame_end & (r_kind_ack | r_frame_hi);

    always_comb begin
        n_state     = r_state;
        n_kind_ack  = r_kind_ack;
        n_frame_hi  = r_frame_hi;
        n_idx       = r_idx;
        o_cmd       = '0;
        o_cmd.rx_take  = rx_take;
        o_cmd.kind_ack = r_kind_ack;
        o_cmd.frame_hi = r_frame_hi;
        o_cmd.idx      = r_idx;
        case (r_state)
            S_RX: begin
                if (rx_take && i_s_last) begin
                    if (i_stat.act == cfcr_pkg::ACT_READ || i_stat.act == cfcr_pkg::ACT_ACK) begin
                        n_state    = S_REPLY;
                        n_kind_ack = (i_stat.act == cfcr_pkg::ACT_ACK);
                        n_frame_hi = 1'b0;
                        n_idx      = '0;
                    end else begin
                        o_cmd.out_load   = 1'b1;
                        o_cmd.out_single = 1'b1;
                    end
                end
            end
            S_REPLY: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_last = run_end;
                    n_idx          = r_idx + 5'd1;
                    if (frame_end) begin
                        n_idx = '0;
                        if (run_end) begin
                            n_state = S_RX;
                        end else begin
                            n_frame_hi = 1'b1;
                        end
                    end
                end
            end
            default: n_state = S_RX;
        endcase
        n_out_valid = o_cmd.out_load | (r_out_valid & ~i_m_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RX;
            r_kind_ack  <= 1'b0;
            r_frame_hi  <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kind_ack  <= n_kind_ack;
            r_frame_hi  <= n_frame_hi;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

@@ rtl/checksum_frame_command_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// checksum_frame_command_receiver
// Command frame receiver with additive checksum, gain store and reply frames.
// ----------------------------------------------------------------------------
// Input stream: one received byte per request, tlast on the checksum byte.
// Output stream: one request per reply byte, or a single empty request when
// a frame has no reply; tlast marks the final request for a received frame.
// Non-final bytes produce nothing. The checksum byte
// is checked in its accept cycle; an empty result is registered at once,
// while a reply is sent by the sequencer one byte per cycle whenever the output
// register is free: 8 bytes for an acknowledge, 46 for the two gain readout frames.
// Input is held off (s_axis tready low) while a reply is being sent and
// while the output register is full and not being drained.
// A result left waiting by a stalled receiver therefore holds off every
// input byte, not only the next checksum byte, until it is taken.
// Reset clears the parser state, the output valid flag and all 18 gains.
// ----------------------------------------------------------------------------
module checksum_frame_command_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] rx_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] tx_byte
    output logic       o_m_axis_tlast,
    output logic [5:0] o_m_axis_tuser    // [0] byte_valid, [2:1] frame_status,
                                         // [3] acc_cal, [4] gyro_cal, [5] save_gains
);

    cfcr_pkg::t_dp_cmd  cmd;
    cfcr_pkg::t_dp_stat stat;
    logic [1:0] frame_status;
    logic       byte_valid;
    logic       acc_cal;
    logic       gyro_cal;
    logic       save;

    cfcr_controller u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .i_s_last  (i_s_axis_tlast),
        .o_s_ready (o_s_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .i_stat    (stat),
        .o_cmd     (cmd)
    );

    cfcr_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_byte      (i_s_axis_tdata),
        .i_rx_last      (i_s_axis_tlast),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_tx_byte      (o_m_axis_tdata),
        .o_byte_valid   (byte_valid),
        .o_last_of_run  (o_m_axis_tlast),
        .o_frame_status (frame_status),
        .o_acc_cal      (acc_cal),
        .o_gyro_cal     (gyro_cal),
        .o_save         (save)
    );

    assign o_m_axis_tuser = {save, gyro_cal, acc_cal, frame_status, byte_valid};

endmodule

@@ dv/tb_checksum_frame_command_receiver.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checksum_frame_command_receiver
// Self-checking bench for the checksum frame command receiver. Frames are sent
// byte by byte on the input stream; a parser model tracks the sum, header,
// function, staged payload and gain store, and queues the reply requests each
// frame must produce. A directed table covers error codes, every function and
// long frames; random well-formed and broken frames follow, with random idling
// on both streams.
// ----------------------------------------------------------------------------
module tb_checksum_frame_command_receiver;

    localparam int         RANDOM_BYTES = 210;
    localparam int         QUIET_LIMIT  = 4000;
    localparam int         TAIL_CYCLES  = 60;
    localparam logic [7:0] FN_NONE      = 8'h00;
    localparam logic [7:0] FN_TOP       = 8'hFF;

    // short names for the directed table
    localparam logic [7:0] SYNC     = cfcr_pkg::HDR_SYNC;
    localparam logic [7:0] RX_ID    = cfcr_pkg::HDR_RX_ID;
    localparam logic [7:0] F_CAL    = cfcr_pkg::FN_CAL;
    localparam logic [7:0] F_READ   = cfcr_pkg::FN_READ;
    localparam logic [7:0] F_SET_LO = cfcr_pkg::FN_SET_LO;
    localparam logic [7:0] F_SET_HI = cfcr_pkg::FN_SET_HI;
    localparam logic [7:0] F_SAVE   = cfcr_pkg::FN_SAVE;
    localparam logic [7:0] S_READ   = cfcr_pkg::SUB_READ;
    localparam logic [7:0] S_ACC    = cfcr_pkg::SUB_ACC;
    localparam logic [7:0] S_GYRO   = cfcr_pkg::SUB_GYRO;
    localparam logic [7:0] S_BOTH   = cfcr_pkg::SUB_BOTH;
    localparam logic [1:0] ST_OK    = cfcr_pkg::FS_OK;
    localparam logic [1:0] ST_SUM   = cfcr_pkg::FS_BAD_SUM;
    localparam logic [1:0] ST_HDR   = cfcr_pkg::FS_BAD_HDR;
    localparam logic [1:0] ST_SHORT = cfcr_pkg::FS_SHORT;

    typedef struct packed {
        logic [7:0] tx;
        logic       vld;
        logic       last;
        logic [1:0] st;
        logic       acc;
        logic       gyro;
        logic       save;
    } t_reply;

    typedef struct packed {
        logic [7:0] h0;
        logic [7:0] h1;
        logic [7:0] fn;
        logic [7:0] sub;
        logic [7:0] fill_hi;
        logic [7:0] fill_lo;
        logic [8:0] len;
        logic [7:0] delta;
        logic       typed;
        logic [1:0] st;
    } t_dir_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_valid = 1'b0;
    logic [7:0] s_data = 8'h00;
    logic       s_last = 1'b0;
    logic       m_ready = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_data;
    logic       m_last;
    logic [5:0] m_user;

    // parser model state
    logic [7:0]  rx_sum = '0;
    logic [7:0]  rx_pos = '0;
    logic        hdr_ok = 1'b0;
    logic [7:0]  fn_code = '0;
    logic [7:0]  sub_code = '0;
    logic [7:0]  stage [cfcr_pkg::PAYLOAD_LEN];
    logic [15:0] gains [cfcr_pkg::GAIN_COUNT];

    t_reply     replies_due [$];
    logic [7:0] reply_bytes [$];
    logic [7:0] frame_bytes [$];
    t_dir_row   dir_rows [$];

    bit calm = 1'b0;
    int bytes_sent = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    checksum_frame_command_receiver dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial begin
        for (int i = 0; i < cfcr_pkg::GAIN_COUNT; i++) gains[i] = '0;
        for (int i = 0; i < cfcr_pkg::PAYLOAD_LEN; i++) stage[i] = '0;
    end

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endtask

    task automatic add_gain_frame(input logic [7:0] code, input int base);
        logic [7:0] sum;
        sum = 8'(cfcr_pkg::HDR_SYNC + cfcr_pkg::HDR_SYNC + code + cfcr_pkg::GAIN_LEN_BYTE);
        reply_bytes.push_back(cfcr_pkg::HDR_SYNC);
        reply_bytes.push_back(cfcr_pkg::HDR_SYNC);
        reply_bytes.push_back(code);
        reply_bytes.push_back(cfcr_pkg::GAIN_LEN_BYTE);
        for (int i = 0; i < cfcr_pkg::GAIN_HALF; i++) begin
            reply_bytes.push_back(gains[base + i][15:8]);
            reply_bytes.push_back(gains[base + i][7:0]);
            sum = sum + gains[base + i][15:8] + gains[base + i][7:0];
        end
        reply_bytes.push_back(sum);
    endtask

    task automatic add_ack_frame(input logic [7:0] chk);
        reply_bytes.push_back(cfcr_pkg::HDR_SYNC);
        reply_bytes.push_back(cfcr_pkg::HDR_SYNC);
        reply_bytes.push_back(cfcr_pkg::ACK_CODE);
        reply_bytes.push_back(cfcr_pkg::ACK_LEN_BYTE);
        reply_bytes.push_back(cfcr_pkg::ACK_TAG);
        reply_bytes.push_back(8'h00);
        reply_bytes.push_back(chk);
        reply_bytes.push_back(8'(cfcr_pkg::HDR_SYNC + cfcr_pkg::HDR_SYNC + cfcr_pkg::ACK_CODE +
                                 cfcr_pkg::ACK_LEN_BYTE + cfcr_pkg::ACK_TAG + chk));
    endtask

    task automatic commit_stage(input int base);
        for (int i = 0; i < cfcr_pkg::GAIN_HALF; i++) begin
            gains[base + i] = {stage[2 * i], stage[2 * i + 1]};
        end
    endtask

    // Model one accepted byte; on the checksum byte queue the frame's replies.
    // A typed row replaces the modeled reply with its single empty request.
    task automatic parse_byte(input logic [7:0] b, input logic eof, input bit typed,
                              input logic [1:0] typed_st);
        logic [1:0] st;
        logic [7:0] need;
        logic       acc;
        logic       gyro;
        logic       save;
        int         cnt;
        st   = cfcr_pkg::FS_OK;
        acc  = 1'b0;
        gyro = 1'b0;
        save = 1'b0;
        if (!eof) begin
            if (rx_pos == 8'd0) hdr_ok = (b == cfcr_pkg::HDR_SYNC);
            else if (rx_pos == 8'd1) hdr_ok = hdr_ok && (b == cfcr_pkg::HDR_RX_ID);
            if (rx_pos == 8'd2) fn_code = b;
            if (rx_pos == 8'd4) sub_code = b;
            if (rx_pos >= cfcr_pkg::PAYLOAD_FIRST && rx_pos < cfcr_pkg::PAYLOAD_END) begin
                stage[rx_pos - cfcr_pkg::PAYLOAD_FIRST] = b;
            end
            rx_sum = rx_sum + b;
            if (rx_pos != 8'hFF) rx_pos = rx_pos + 8'd1;
        end else begin
            reply_bytes.delete();
            if (rx_sum != b) begin
                st = cfcr_pkg::FS_BAD_SUM;
            end else if (!(hdr_ok && rx_pos >= 8'd2)) begin
                st = cfcr_pkg::FS_BAD_HDR;
            end else begin
                need = cfcr_pkg::NEED_ANY;
                if (fn_code == cfcr_pkg::FN_CAL || fn_code == cfcr_pkg::FN_READ) begin
                    need = cfcr_pkg::NEED_SHORT;
                end else if (fn_code == cfcr_pkg::FN_SET_LO ||
                             fn_code == cfcr_pkg::FN_SET_HI) begin
                    need = cfcr_pkg::NEED_GAINS;
                end
                if (rx_pos < need) st = cfcr_pkg::FS_SHORT;
            end
            if (st == cfcr_pkg::FS_OK) begin
                case (fn_code)
                    cfcr_pkg::FN_CAL: begin
                        acc  = (sub_code == cfcr_pkg::SUB_ACC) ||
                               (sub_code == cfcr_pkg::SUB_BOTH);
                        gyro = (sub_code == cfcr_pkg::SUB_GYRO) ||
                               (sub_code == cfcr_pkg::SUB_BOTH);
                    end
                    cfcr_pkg::FN_READ: begin
                        if (sub_code == cfcr_pkg::SUB_READ) begin
                            add_gain_frame(cfcr_pkg::GAIN_CODE_LO, 0);
                            add_gain_frame(cfcr_pkg::GAIN_CODE_HI, cfcr_pkg::GAIN_HALF);
                        end
                    end
                    cfcr_pkg::FN_SET_LO: begin
                        commit_stage(0);
                        add_ack_frame(rx_sum);
                    end
                    cfcr_pkg::FN_SET_HI: begin
                        commit_stage(cfcr_pkg::GAIN_HALF);
                        add_ack_frame(rx_sum);
                    end
                    cfcr_pkg::FN_SAVE: begin
                        add_ack_frame(rx_sum);
                        save = 1'b1;
                    end
                    default: ;
                endcase
            end
            if (typed) begin
                replies_due.push_back('{8'h00, 1'b0, 1'b1, typed_st, 1'b0, 1'b0, 1'b0});
            end else begin
                cnt = (reply_bytes.size() == 0) ? 1 : reply_bytes.size();
                for (int k = 0; k < cnt; k++) begin
                    replies_due.push_back('{
                        (reply_bytes.size() == 0) ? 8'h00 : reply_bytes[k],
                        reply_bytes.size() != 0,
                        k == cnt - 1,
                        st,
                        (k == cnt - 1) && acc,
                        (k == cnt - 1) && gyro,
                        (k == cnt - 1) && save});
                end
            end
            rx_sum   = '0;
            rx_pos   = '0;
            hdr_ok   = 1'b0;
            fn_code  = '0;
            sub_code = '0;
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eof, input bit typed,
                             input logic [1:0] typed_st);
        while (!calm && $urandom_range(99) < 17) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_last  <= eof;
        do @(posedge clk); while (!s_ready);
        bytes_sent++;
        parse_byte(b, eof, typed, typed_st);
    endtask

    task automatic send_frame(input logic [7:0] delta, input bit typed, input logic [1:0] st);
        logic [7:0] sum;
        sum = '0;
        foreach (frame_bytes[i]) begin
            push_byte(frame_bytes[i], 1'b0, 1'b0, cfcr_pkg::FS_OK);
            sum = sum + frame_bytes[i];
        end
        push_byte(sum + delta, 1'b1, typed, st);
    endtask

    task automatic drain_replies();
        s_valid <= 1'b0;
        do @(posedge clk); while (replies_due.size() != 0);
    endtask

    task automatic row(input logic [7:0] h0, input logic [7:0] h1, input logic [7:0] fn,
                       input logic [7:0] sub, input logic [7:0] fill_hi,
                       input logic [7:0] fill_lo, input int len, input logic [7:0] delta,
                       input bit typed, input logic [1:0] st);
        t_dir_row r;
        r.h0      = h0;
        r.h1      = h1;
        r.fn      = fn;
        r.sub     = sub;
        r.fill_hi = fill_hi;
        r.fill_lo = fill_lo;
        r.len     = 9'(len);
        r.delta   = delta;
        r.typed   = typed;
        r.st      = st;
        dir_rows.push_back(r);
    endtask

    always @(posedge clk) begin
        m_ready <= calm || ($urandom_range(99) >= 17);
    end

    always @(posedge clk) begin
        t_reply got;
        t_reply want;
        if (rst_n && m_valid && m_ready) begin
            got = {m_data, m_user[0], m_last, m_user[2:1], m_user[3], m_user[4], m_user[5]};
            if (replies_due.size() == 0) begin
                note_mismatch($sformatf("unexpected reply tx=%h tlast=%b tuser=%b",
                                        m_data, m_last, m_user));
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    note_mismatch($sformatf({
                        "reply mismatch: exp tx=%h v=%b last=%b st=%0d acc=%b gyro=%b",
                        " save=%b, got tx=%h v=%b last=%b st=%0d acc=%b gyro=%b save=%b"},
                        want.tx, want.vld, want.last, want.st, want.acc, want.gyro, want.save,
                        got.tx, got.vld, got.last, got.st, got.acc, got.gyro, got.save));
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb_checksum_frame_command_receiver: FAIL");
            $finish;
        end
    end

    initial begin
        int         kind;
        int         len;
        int         frames;
        logic [7:0] delta;
        logic [7:0] fn;
        logic [7:0] sub;
        logic       good_hdr;
        t_dir_row   r;

        //   h0    h1     fn        sub     hi     lo    len  delta  typed status
        // gain store reads back zero after reset
        row(SYNC,  RX_ID, F_READ,   S_READ, 8'h00, 8'h00,  5, 8'h00, 0, ST_OK);
        row(SYNC,  RX_ID, FN_NONE,  8'h00,  8'h00, 8'h00,  3, 8'h00, 1, ST_OK);
        row(SYNC,  RX_ID, FN_TOP,   8'hFF,  8'hFF, 8'hFF,  9, 8'h00, 1, ST_OK);
        row(SYNC,  RX_ID, F_SAVE,   8'h00,  8'h00, 8'h00,  3, 8'h01, 1, ST_SUM);
        row(SYNC,  RX_ID, F_CAL,    S_BOTH, 8'hFF, 8'hFF,  9, 8'hFF, 1, ST_SUM);
        // checksum byte alone, then a header cut off after its first byte
        row(SYNC,  RX_ID, F_SAVE,   8'h00,  8'h00, 8'h00,  0, 8'h00, 1, ST_HDR);
        row(SYNC,  RX_ID, F_SAVE,   8'h00,  8'h00, 8'h00,  1, 8'h00, 1, ST_HDR);
        row(SYNC,  8'h00, F_CAL,    S_ACC,  8'h00, 8'h00,  5, 8'h00, 1, ST_HDR);
        row(8'h00, RX_ID, F_SAVE,   8'h00,  8'h00, 8'h00,  3, 8'h00, 1, ST_HDR);
        row(SYNC,  RX_ID, F_SAVE,   8'h00,  8'h00, 8'h00,  2, 8'h00, 1, ST_SHORT);
        row(SYNC,  RX_ID, F_CAL,    S_ACC,  8'h00, 8'h00,  4, 8'h00, 1, ST_SHORT);
        row(SYNC,  RX_ID, F_SET_LO, 8'h12,  8'h34, 8'h56, 21, 8'h00, 1, ST_SHORT);
        row(SYNC,  RX_ID, F_CAL,    S_ACC,  8'h00, 8'h00,  5, 8'h00, 0, ST_OK);
        row(SYNC,  RX_ID, F_CAL,    S_GYRO, 8'h00, 8'h00,  5, 8'h00, 0, ST_OK);
        row(SYNC,  RX_ID, F_CAL,    S_BOTH, 8'h00, 8'h00,  6, 8'h00, 0, ST_OK);
        row(SYNC,  RX_ID, F_CAL,    8'h00,  8'h00, 8'h00,  5, 8'h00, 0, ST_OK);
        // largest positive gains low half, most negative high half
        row(SYNC,  RX_ID, F_SET_LO, 8'h7F,  8'h7F, 8'hFF, 22, 8'h00, 0, ST_OK);
        row(SYNC,  RX_ID, F_SET_HI, 8'h80,  8'h80, 8'h00, 22, 8'h00, 0, ST_OK);
        row(SYNC,  RX_ID, F_READ,   S_READ, 8'h00, 8'h00,  5, 8'h00, 0, ST_OK);
        row(SYNC,  RX_ID, F_READ,   S_GYRO, 8'h00, 8'h00,  5, 8'h00, 1, ST_OK);
        row(SYNC,  RX_ID, F_SAVE,   8'h00,  8'h00, 8'h00,  3, 8'h00, 0, ST_OK);
        // trailing bytes only summed
        row(SYNC,  RX_ID, F_SET_LO, 8'hFF,  8'hFF, 8'h00, 30, 8'h00, 0, ST_OK);
        row(SYNC,  RX_ID, F_READ,   S_READ, 8'h00, 8'h00,  5, 8'h00, 0, ST_OK);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            frame_bytes.delete();
            for (int p = 0; p < r.len; p++) begin
                case (p)
                    0: frame_bytes.push_back(r.h0);
                    1: frame_bytes.push_back(r.h1);
                    2: frame_bytes.push_back(r.fn);
                    3: frame_bytes.push_back(r.len[7:0]);
                    4: frame_bytes.push_back(r.sub);
                    default: frame_bytes.push_back((p % 2 == 0) ? r.fill_hi : r.fill_lo);
                endcase
            end
            send_frame(r.delta, r.typed, r.st);
        end
        drain_replies();

        bytes_sent = 0;
        frames = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            calm <= (bytes_sent >= 60 && bytes_sent < 170);
            if (frames % 9 == 8) drain_replies();
            frames++;
            kind     = $urandom_range(99);
            good_hdr = 1'b1;
            delta    = 8'h00;
            sub      = 8'($urandom);
            if (kind < 15) begin
                fn  = cfcr_pkg::FN_CAL;
                sub = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
                len = 5 + $urandom_range(3);
            end else if (kind < 35) begin
                fn  = cfcr_pkg::FN_READ;
                if ($urandom_range(9) != 0) sub = cfcr_pkg::SUB_READ;
                len = 5 + $urandom_range(2);
            end else if (kind < 60) begin
                fn  = $urandom_range(1) ? cfcr_pkg::FN_SET_HI : cfcr_pkg::FN_SET_LO;
                len = 22 + (($urandom_range(5) == 0) ? $urandom_range(6) : 0);
            end else if (kind < 72) begin
                fn  = cfcr_pkg::FN_SAVE;
                len = 3 + $urandom_range(3);
            end else if (kind < 78) begin
                fn  = 8'($urandom);
                len = 3 + $urandom_range(5);
            end else begin
                fn       = 8'($urandom);
                len      = $urandom_range(24);
                good_hdr = 1'($urandom_range(1));
                if ($urandom_range(1)) delta = 8'($urandom);
            end
            if (kind < 78) begin
                case ($urandom_range(11))
                    0: delta = 8'($urandom_range(255, 1));
                    1: len = $urandom_range(len - 1);
                    default: ;
                endcase
            end
            frame_bytes.delete();
            for (int p = 0; p < len; p++) begin
                case (p)
                    0: frame_bytes.push_back(good_hdr ? cfcr_pkg::HDR_SYNC : 8'($urandom));
                    1: frame_bytes.push_back(good_hdr ? cfcr_pkg::HDR_RX_ID : 8'($urandom));
                    2: frame_bytes.push_back(fn);
                    4: frame_bytes.push_back(sub);
                    default: frame_bytes.push_back(8'($urandom));
                endcase
            end
            send_frame(delta, 1'b0, cfcr_pkg::FS_OK);
        end
        calm <= 1'b0;
        drain_replies();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("tb_checksum_frame_command_receiver: PASS");
        end else begin
            $display("tb_checksum_frame_command_receiver: FAIL");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/cfcr_pkg.sv
rtl/cfcr_datapath.sv
rtl/cfcr_controller.sv
rtl/checksum_frame_command_receiver.sv
dv/tb_checksum_frame_command_receiver.sv
